// File: rtl/jsu_pkg.sv
// Package for the JSON string unescape unit: result/command types, mode and
// error codes, UTF-8 constants. No dependencies.
package jsu_pkg;

  localparam int JSU_FIFO_DEPTH = 4;
  localparam int MAX_RESULTS    = 3;

  typedef enum logic [4:0] {
    MODE_IDLE = 5'b00001,
    MODE_STR  = 5'b00010,
    MODE_ESC  = 5'b00100,
    MODE_HEX  = 5'b01000,
    MODE_ERR  = 5'b10000
  } mode_t;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  localparam logic [2:0] ERR_NO_QUOTE     = 3'd0;
  localparam logic [2:0] ERR_TRUNC_ESCAPE = 3'd1;
  localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
  localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd3;
  localparam logic [2:0] ERR_CONTROL      = 3'd4;
  localparam logic [2:0] ERR_UNTERMINATED = 3'd5;
  localparam logic [2:0] ERR_NONE         = 3'd0;

  localparam logic [7:0] UTF8_LEAD2    = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3    = 8'hE0;
  localparam logic [7:0] UTF8_CONT     = 8'h80;
  localparam logic [7:0] CTRL_LIMIT    = 8'h20;
  localparam logic [15:0] CP_ONE_BYTE  = 16'h0080;
  localparam logic [15:0] CP_TWO_BYTE  = 16'h0800;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [2:0] err;
  } result_t;

  // One decoded input byte: up to three results, count of zero never queued
  typedef struct packed {
    logic [1:0]                     count;
    result_t [MAX_RESULTS-1:0]      item;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

// File: rtl/jsu_front.sv
// Front end: accepts text bytes, tracks the string/escape mode and turns each
// byte into a command of up to three results. Depends on jsu_pkg.
module jsu_front import jsu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          text_valid,
  input  logic [7:0]    text_byte,
  input  logic          end_of_text,
  input  queue_status_t q_status,
  output logic          text_stall,
  output logic          push,
  output cmd_t          cmd
);

  mode_t       mode, mode_next;
  logic [1:0]  hex_count, hex_count_next;
  logic [11:0] code_accum, code_accum_next;

  logic        accept;
  logic        is_hex;
  logic [3:0]  nib;
  logic [15:0] cp;
  logic [7:0]  esc_byte;
  logic        esc_simple;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= "0" && c <= "9") begin
      r = {1'b1, c[3:0]};
    end else if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  assign text_stall = q_status.full;
  assign accept     = text_valid && !q_status.full;
  assign push       = accept && (cmd.count != 2'd0);

  assign {is_hex, nib} = hex_decode(text_byte);
  assign cp = {code_accum, nib};

  always_comb begin
    esc_simple = 1'b1;
    esc_byte   = 8'h00;
    case (text_byte)
      "\"":    esc_byte = "\"";
      "\\":    esc_byte = "\\";
      "/":     esc_byte = "/";
      "b":     esc_byte = 8'h08;
      "f":     esc_byte = 8'h0C;
      "n":     esc_byte = 8'h0A;
      "r":     esc_byte = 8'h0D;
      "t":     esc_byte = 8'h09;
      default: esc_simple = 1'b0;
    endcase
  end

  always_comb begin
    cmd             = '0;
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    case (mode)
      MODE_IDLE: begin
        if (text_byte inside {8'h20, 8'h09, 8'h0D, 8'h0A}) begin
          mode_next = MODE_IDLE;
        end else if (text_byte == "\"") begin
          mode_next = MODE_STR;
          if (end_of_text) begin
            cmd.count   = 2'd1;
            cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_UNTERMINATED};
            mode_next   = MODE_IDLE;
          end
        end else begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_NO_QUOTE};
          mode_next   = end_of_text ? MODE_IDLE : MODE_ERR;
        end
      end
      MODE_STR: begin
        if (text_byte == "\"") begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_CLOSE, 8'h00, ERR_NONE};
          mode_next   = MODE_IDLE;
        end else if (text_byte == "\\") begin
          if (end_of_text) begin
            cmd.count   = 2'd1;
            cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_TRUNC_ESCAPE};
            mode_next   = MODE_IDLE;
          end else begin
            mode_next = MODE_ESC;
          end
        end else if (text_byte < CTRL_LIMIT) begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_CONTROL};
          mode_next   = end_of_text ? MODE_IDLE : MODE_ERR;
        end else begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_DATA, text_byte, ERR_NONE};
          if (end_of_text) begin
            cmd.count   = 2'd2;
            cmd.item[1] = '{KIND_ERROR, 8'h00, ERR_UNTERMINATED};
            mode_next   = MODE_IDLE;
          end
        end
      end
      MODE_ESC: begin
        if (esc_simple) begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_DATA, esc_byte, ERR_NONE};
          mode_next   = MODE_STR;
          if (end_of_text) begin
            cmd.count   = 2'd2;
            cmd.item[1] = '{KIND_ERROR, 8'h00, ERR_UNTERMINATED};
            mode_next   = MODE_IDLE;
          end
        end else if (text_byte == "u") begin
          if (end_of_text) begin
            cmd.count   = 2'd1;
            cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_TRUNC_ESCAPE};
            mode_next   = MODE_IDLE;
          end else begin
            mode_next       = MODE_HEX;
            hex_count_next  = 2'd0;
            code_accum_next = 12'd0;
          end
        end else begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_UNKNOWN_ESC};
          mode_next   = end_of_text ? MODE_IDLE : MODE_ERR;
        end
      end
      MODE_HEX: begin
        hex_count_next  = 2'd0;
        code_accum_next = 12'd0;
        if (end_of_text) begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_TRUNC_ESCAPE};
          mode_next   = MODE_IDLE;
        end else if (!is_hex) begin
          cmd.count   = 2'd1;
          cmd.item[0] = '{KIND_ERROR, 8'h00, ERR_BAD_HEX};
          mode_next   = MODE_ERR;
        end else if (hex_count != 2'd3) begin
          hex_count_next  = hex_count + 2'd1;
          code_accum_next = cp[11:0];
        end else begin
          mode_next = MODE_STR;
          if (cp < CP_ONE_BYTE) begin
            cmd.count   = 2'd1;
            cmd.item[0] = '{KIND_DATA, cp[7:0], ERR_NONE};
          end else if (cp < CP_TWO_BYTE) begin
            cmd.count   = 2'd2;
            cmd.item[0] = '{KIND_DATA, UTF8_LEAD2 | {3'b000, cp[10:6]}, ERR_NONE};
            cmd.item[1] = '{KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]}, ERR_NONE};
          end else begin
            cmd.count   = 2'd3;
            cmd.item[0] = '{KIND_DATA, UTF8_LEAD3 | {4'b0000, cp[15:12]}, ERR_NONE};
            cmd.item[1] = '{KIND_DATA, UTF8_CONT | {2'b00, cp[11:6]}, ERR_NONE};
            cmd.item[2] = '{KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]}, ERR_NONE};
          end
        end
      end
      MODE_ERR: begin
        mode_next = end_of_text ? MODE_IDLE : MODE_ERR;
      end
      default: begin
        mode_next = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_accum <= 12'd0;
    end else if (accept) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
    end
  end

endmodule

// File: rtl/jsu_queue.sv
// Command queue between front and back end, a small circular buffer.
// Depends on jsu_pkg.
module jsu_queue import jsu_pkg::*; #(
  parameter int DEPTH = JSU_FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  cmd_t          push_cmd,
  input  logic          pop,
  output cmd_t          head,
  output queue_status_t status
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);

  cmd_t            mem [DEPTH];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push, do_pop;

  assign status.full  = (count == CntW'(DEPTH));
  assign status.empty = (count == '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/jsu_back.sv
// Back end: moves queue-head results one per cycle, unless stalled, into the
// output register and marks the final result of each byte. Depends on jsu_pkg.
module jsu_back import jsu_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  cmd_t          head,
  input  queue_status_t q_status,
  output logic          pop,
  input  logic          result_stall,
  output logic          result_valid,
  output logic [1:0]    kind,
  output logic [7:0]    data_byte,
  output logic [2:0]    error_code,
  output logic          last
);

  logic [1:0] slot;
  logic       load;
  logic       slot_last;
  result_t    cur;

  assign load      = (!result_valid || !result_stall) && !q_status.empty;
  assign slot_last = (slot == head.count - 2'd1);
  assign pop       = load && slot_last;
  assign cur       = head.item[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      slot         <= 2'd0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        slot         <= slot_last ? 2'd0 : slot + 2'd1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind       <= cur.kind;
      data_byte  <= cur.data;
      error_code <= cur.err;
      last       <= slot_last;
    end
  end

endmodule

// File: rtl/json_string_unescape_unit.sv
// Top level of the JSON string unescape unit: front end, command queue and
// back end. Depends on jsu_pkg, jsu_front, jsu_queue, jsu_back.
//
// Input channel: text_byte/end_of_text with text_valid, text_stall. One raw
// byte is taken per cycle while the command queue has room; text_stall is
// the queue-full flag.
// Output channel: kind/data_byte/error_code/last with result_valid and
// result_stall. One result leaves per cycle while result_stall is low; last
// marks the final result caused by one input byte. Bytes that cause no
// result (whitespace, the opening quote, escape prefixes, the first three
// hex digits of a \u escape, bytes after an error) are absorbed.
// The edge that takes a byte writes its command into the queue; the output
// register then loads its results from the queue head.
// Throughput: one byte per cycle sustained while each gives at most one
// result and the receiver does not stall; a \u escape emitting two or three
// UTF-8 bytes holds the back end; the FIFO_DEPTH-command queue absorbs this.
// When the receiver stalls, the output register holds, the queue fills and
// text_stall rises once it is full.
// Reset (rst, synchronous): mode goes idle, queue and output are emptied.
module json_string_unescape_unit import jsu_pkg::*; #(
  parameter int FIFO_DEPTH = JSU_FIFO_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       result_valid,
  input  logic       result_stall,
  output logic [1:0] kind,
  output logic [7:0] data_byte,
  output logic [2:0] error_code,
  output logic       last
);

  queue_status_t q_status;
  cmd_t          push_cmd, head;
  logic          push, pop;

  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_byte  (text_byte),
    .end_of_text(end_of_text),
    .q_status   (q_status),
    .text_stall (text_stall),
    .push       (push),
    .cmd        (push_cmd)
  );

  jsu_queue #(
    .DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .head    (head),
    .status  (q_status)
  );

  jsu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .result_stall(result_stall),
    .result_valid(result_valid),
    .kind        (kind),
    .data_byte   (data_byte),
    .error_code  (error_code),
    .last        (last)
  );

endmodule

// File: sim/tb_top.sv
// Testbench for json_string_unescape_unit: directed table plus random JSON texts,
// every result checked against the table or an in-bench decoder model.
// Depends on jsu_pkg and the RTL of the unit; standalone otherwise.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jsu_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int TOTAL_ITEMS   = 170;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_ROWS      = 31;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [7:0] ESC_LETTERS [8] = '{8'h22, 8'h5C, 8'h2F, 8'h62,
                                             8'h66, 8'h6E, 8'h72, 8'h74};
  localparam logic [7:0] WS_CHARS [4] = '{8'h20, 8'h09, 8'h0D, 8'h0A};

  typedef struct {
    kind_t      kind;
    logic [7:0] data;
    logic [2:0] err;
    logic       last;
  } decoded_t;

  typedef struct {
    logic [7:0] txt;
    logic       eot;
    bit         typed;       // expectation written in the row, not predicted
    bit         has_result;
    kind_t      kind;
    logic [7:0] data;
    logic [2:0] err;
  } stim_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       text_valid = 1'b0;
  logic       text_stall;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       result_valid;
  logic       result_stall = 1'b0;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic [2:0] error_code;
  logic       last;

  decoded_t pending_results [$];
  int       failures = 0;
  int       quiet_cycles = 0;
  int       burst_left = 0;
  int       hold_left = 0;
  int       flow_left = 0;
  int       counted_requests = 0;

  // decoder model state
  mode_t       scan_mode = MODE_IDLE;
  logic [1:0]  hex_digits = 2'd0;
  logic [11:0] hex_accum = 12'h000;

  json_string_unescape_unit DUT (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_byte    (text_byte),
    .end_of_text  (end_of_text),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .data_byte    (data_byte),
    .error_code   (error_code),
    .last         (last)
  );

  always #5ns clk = ~clk;

  function automatic bit is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit is_simple_escape(input logic [7:0] c);
    for (int i = 0; i < 8; i++) begin
      if (ESC_LETTERS[i] == c) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    return -1;
  endfunction

  function automatic decoded_t make_result(input kind_t k, input logic [7:0] d,
                                           input logic [2:0] e);
    decoded_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic decoded_t flag_error(input logic [2:0] e, input logic eot);
    scan_mode  = eot ? MODE_IDLE : MODE_ERR;
    hex_digits = 2'd0;
    hex_accum  = 12'h000;
    return make_result(KIND_ERROR, 8'h00, e);
  endfunction

  // Advances the model by one text byte; returns the number of results.
  function automatic int decode_text_byte(input logic [7:0] c, input logic eot,
                                          output decoded_t res [3]);
    int          n;
    int          h;
    logic [7:0]  d;
    logic [15:0] cp;
    n = 0;
    case (scan_mode)
      MODE_IDLE: begin
        if (c == CH_QUOTE) begin
          scan_mode = MODE_STR;
          if (eot) begin
            res[n] = flag_error(ERR_UNTERMINATED, 1'b1);
            n++;
          end
        end else if (!is_space(c)) begin
          res[n] = flag_error(ERR_NO_QUOTE, eot);
          n++;
        end
      end
      MODE_STR: begin
        if (c == CH_QUOTE) begin
          res[n] = make_result(KIND_CLOSE, 8'h00, ERR_NONE);
          n++;
          scan_mode = MODE_IDLE;
        end else if (c == CH_BSLASH) begin
          if (eot) begin
            res[n] = flag_error(ERR_TRUNC_ESCAPE, 1'b1);
            n++;
          end else begin
            scan_mode = MODE_ESC;
          end
        end else if (c < CTRL_LIMIT) begin
          res[n] = flag_error(ERR_CONTROL, eot);
          n++;
        end else begin
          res[n] = make_result(KIND_DATA, c, ERR_NONE);
          n++;
          if (eot) begin
            res[n] = flag_error(ERR_UNTERMINATED, 1'b1);
            n++;
          end
        end
      end
      MODE_ESC: begin
        h = 1;
        case (c)
          CH_QUOTE:  d = CH_QUOTE;
          CH_BSLASH: d = CH_BSLASH;
          CH_SLASH:  d = CH_SLASH;
          8'h62:     d = 8'h08;   // b
          8'h66:     d = 8'h0C;   // f
          8'h6E:     d = 8'h0A;   // n
          8'h72:     d = 8'h0D;   // r
          8'h74:     d = 8'h09;   // t
          default: begin
            d = 8'h00;
            h = 0;
          end
        endcase
        if (h == 1) begin
          res[n] = make_result(KIND_DATA, d, ERR_NONE);
          n++;
          scan_mode = MODE_STR;
          if (eot) begin
            res[n] = flag_error(ERR_UNTERMINATED, 1'b1);
            n++;
          end
        end else if (c == CH_U) begin
          if (eot) begin
            res[n] = flag_error(ERR_TRUNC_ESCAPE, 1'b1);
            n++;
          end else begin
            scan_mode  = MODE_HEX;
            hex_digits = 2'd0;
            hex_accum  = 12'h000;
          end
        end else begin
          res[n] = flag_error(ERR_UNKNOWN_ESC, eot);
          n++;
        end
      end
      MODE_HEX: begin
        h = hex_nibble(c);
        if (eot) begin
          res[n] = flag_error(ERR_TRUNC_ESCAPE, 1'b1);
          n++;
        end else if (h < 0) begin
          res[n] = flag_error(ERR_BAD_HEX, 1'b0);
          n++;
        end else if (hex_digits != 2'd3) begin
          hex_accum  = {hex_accum[7:0], h[3:0]};
          hex_digits = hex_digits + 2'd1;
        end else begin
          cp = {hex_accum, h[3:0]};
          if (cp < CP_ONE_BYTE) begin
            res[0] = make_result(KIND_DATA, cp[7:0], ERR_NONE);
            n = 1;
          end else if (cp < CP_TWO_BYTE) begin
            res[0] = make_result(KIND_DATA, UTF8_LEAD2 | {3'b000, cp[10:6]}, ERR_NONE);
            res[1] = make_result(KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]}, ERR_NONE);
            n = 2;
          end else begin
            res[0] = make_result(KIND_DATA, UTF8_LEAD3 | {4'h0, cp[15:12]}, ERR_NONE);
            res[1] = make_result(KIND_DATA, UTF8_CONT | {2'b00, cp[11:6]}, ERR_NONE);
            res[2] = make_result(KIND_DATA, UTF8_CONT | {2'b00, cp[5:0]}, ERR_NONE);
            n = 3;
          end
          scan_mode  = MODE_STR;
          hex_digits = 2'd0;
          hex_accum  = 12'h000;
        end
      end
      default: scan_mode = eot ? MODE_IDLE : MODE_ERR;
    endcase
    return n;
  endfunction

  // Drives one request and returns at the edge that takes it.
  task automatic put_byte(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        text_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    text_byte   <= b;
    end_of_text <= e;
    text_valid  <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    burst_left--;
    counted_requests++;
  endtask

  task automatic send_and_predict(input logic [7:0] b, input logic e);
    decoded_t res [3];
    int       n;
    put_byte(b, e);
    n = decode_text_byte(b, e, res);
    for (int i = 0; i < n; i++) begin
      res[i].last = (i == n - 1);
      pending_results.insert(pending_results.size(), res[i]);
    end
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'h30 + {4'h0, v};
    return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
  endfunction

  // One random text: mostly a well-formed string, sometimes noise or broken.
  task automatic send_random_text();
    logic [7:0]  text_q [$];
    logic [7:0]  b;
    logic [15:0] cp;
    int          elems;
    int          sel;
    int          cut;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4))
        text_q.insert(text_q.size(), 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 2))
        text_q.insert(text_q.size(), WS_CHARS[$urandom_range(0, 3)]);
      text_q.insert(text_q.size(), CH_QUOTE);
      elems = $urandom_range(0, 6);
      for (int i = 0; i < elems; i++) begin
        sel = $urandom_range(0, 12);
        if (sel <= 4) begin
          do b = 8'($urandom_range(8'h20, 8'hFF));
          while (b == CH_QUOTE || b == CH_BSLASH);
          text_q.insert(text_q.size(), b);
        end else if (sel <= 7) begin
          text_q.insert(text_q.size(), CH_BSLASH);
          text_q.insert(text_q.size(), ESC_LETTERS[$urandom_range(0, 7)]);
        end else if (sel <= 10) begin
          case ($urandom_range(0, 2))
            0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
          endcase
          text_q.insert(text_q.size(), CH_BSLASH);
          text_q.insert(text_q.size(), CH_U);
          for (int k = 3; k >= 0; k--)
            text_q.insert(text_q.size(),
                          hex_char(cp[k*4 +: 4], bit'($urandom_range(0, 1))));
        end else begin
          case ($urandom_range(0, 2))
            0: text_q.insert(text_q.size(), 8'($urandom_range(0, 31)));
            1: begin
              text_q.insert(text_q.size(), CH_BSLASH);
              do b = 8'($urandom_range(0, 255));
              while (b == CH_U || is_simple_escape(b));
              text_q.insert(text_q.size(), b);
            end
            default: begin
              text_q.insert(text_q.size(), CH_BSLASH);
              text_q.insert(text_q.size(), CH_U);
              repeat ($urandom_range(0, 3))
                text_q.insert(text_q.size(), hex_char(4'($urandom_range(0, 15)),
                                                      bit'($urandom_range(0, 1))));
              do b = 8'($urandom_range(0, 255));
              while (hex_nibble(b) >= 0);
              text_q.insert(text_q.size(), b);
            end
          endcase
        end
      end
      text_q.insert(text_q.size(), CH_QUOTE);
      if ($urandom_range(0, 2) == 0)
        text_q.insert(text_q.size(), WS_CHARS[$urandom_range(0, 3)]);
      // cut the text short now and then so it may end inside a string or escape
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, text_q.size());
        while (text_q.size() > cut) void'(text_q.pop_back());
      end
    end
    for (int i = 0; i < text_q.size(); i++)
      send_and_predict(text_q[i], (i == text_q.size() - 1) && ($urandom_range(0, 3) != 0));
  endtask

  // receiver stall pattern: free-running stretches, some long, then short holds
  always @(posedge clk) begin
    if (flow_left > 0) begin
      flow_left--;
      result_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else begin
      flow_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
      hold_left = $urandom_range(1, 8);
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    decoded_t want;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result: kind %0d data %02h err %0d last %0d",
                 kind, data_byte, error_code, last);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, kind);
            failures++;
          end
          if (data_byte !== want.data) begin
            $error("data_byte: expected %02h, actual %02h", want.data, data_byte);
            failures++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, error_code);
            failures++;
          end
          if (last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, last);
            failures++;
          end
        end
      end
      if ((text_valid && !text_stall) || (result_valid && !result_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t rows [NUM_ROWS];
    decoded_t  res [3];
    decoded_t  typed_res;
    int        n;
    // rows: byte, end of text, typed, has result, kind, data, error
    rows = '{
      '{8'h78, 1'b0, 1, 1, KIND_ERROR, 8'h00, ERR_NO_QUOTE},   // stray
      '{8'h61, 1'b1, 1, 0, KIND_DATA, 8'h00, ERR_NONE},        // dropped
      '{CH_SPACE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_TAB, 1'b1, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'hFF, 1'b0, 1, 1, KIND_DATA, 8'hFF, ERR_NONE},
      '{8'h1F, 1'b0, 1, 1, KIND_ERROR, 8'h00, ERR_CONTROL},
      '{8'h00, 1'b1, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_BSLASH, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h71, 1'b0, 1, 1, KIND_ERROR, 8'h00, ERR_UNKNOWN_ESC},
      '{CH_QUOTE, 1'b1, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_BSLASH, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_U, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h47, 1'b0, 1, 1, KIND_ERROR, 8'h00, ERR_BAD_HEX},
      '{8'h7A, 1'b1, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_SPACE, 1'b0, 1, 1, KIND_DATA, 8'h20, ERR_NONE},
      '{CH_BSLASH, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_U, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h46, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h46, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h46, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h66, 1'b0, 0, 0, KIND_DATA, 8'h00, ERR_NONE},      // three bytes
      '{CH_QUOTE, 1'b0, 1, 1, KIND_CLOSE, 8'h00, ERR_NONE},
      '{CH_QUOTE, 1'b1, 1, 1, KIND_ERROR, 8'h00, ERR_UNTERMINATED},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{CH_BSLASH, 1'b1, 1, 1, KIND_ERROR, 8'h00, ERR_TRUNC_ESCAPE},
      '{CH_QUOTE, 1'b0, 1, 0, KIND_DATA, 8'h00, ERR_NONE},
      '{8'h7E, 1'b1, 0, 0, KIND_DATA, 8'h00, ERR_NONE}       // data, then error
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) begin
      put_byte(rows[i].txt, rows[i].eot);
      n = decode_text_byte(rows[i].txt, rows[i].eot, res);
      if (rows[i].typed) begin
        if (rows[i].has_result) begin
          typed_res = make_result(rows[i].kind, rows[i].data, rows[i].err);
          typed_res.last = 1'b1;
          pending_results.insert(pending_results.size(), typed_res);
        end
      end else begin
        for (int k = 0; k < n; k++) begin
          res[k].last = (k == n - 1);
          pending_results.insert(pending_results.size(), res[k]);
        end
      end
    end

    while (counted_requests < TOTAL_ITEMS) send_random_text();
    text_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: json_string_unescape_unit.f
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_unit.sv
sim/tb_top.sv
